[design/rfdc_pkg.sv]
package rfdc_pkg;

    // Field widths
    localparam int unsigned TimeW  = 32;
    localparam int unsigned CfgW   = 31;
    localparam int unsigned PowerW = 7;
    localparam int unsigned ReqW   = 8;
    localparam int unsigned ModeW  = 2;
    localparam int unsigned DutyW  = 8;

    // Mode codes
    localparam logic [ModeW-1:0] MODE_RECYCLE = 2'd0;
    localparam logic [ModeW-1:0] MODE_INHALE  = 2'd1;
    localparam logic [ModeW-1:0] MODE_EXHALE  = 2'd2;

    // Duty and power constants
    localparam logic [DutyW-1:0] NEUTRAL_DUTY = 8'd125;
    localparam logic [DutyW-1:0] INHALE_BASE  = 8'd150;
    localparam logic [DutyW-1:0] EXHALE_BASE  = 8'd100;
    localparam logic [ReqW-1:0]  MAX_POWER    = 8'd100;

    // Register indexes
    localparam logic REG_CYCLE_PERIOD   = 1'b0;
    localparam logic REG_REVERSAL_PAUSE = 1'b1;

    // Stream widths
    localparam int unsigned InDataW  = 48;
    localparam int unsigned OutDataW = 32;

    typedef struct packed {
        logic [TimeW-1:0]  now_ms;
        logic [ReqW-1:0]   power_request;
        logic [ModeW-1:0]  mode_request;
        logic              stop_request;
    } t_item;

    typedef struct packed {
        logic [PowerW-1:0] stored_power;
        logic [ModeW-1:0]  stored_mode;
        logic              direction_inward;
        logic [TimeW-1:0]  last_change_ms;
        logic              in_pause;
    } t_state;

    typedef struct packed {
        logic [DutyW-1:0]  fan_duty;
        logic              relay_on;
        logic signed [7:0] set_power;
        logic signed [7:0] actual_power;
        logic              reversing;
    } t_result;

    // 150 + p*104/100 for p in 0..100; p*1065 >> 10 equals floor(p*1.04) there
    function automatic logic [DutyW-1:0] inhale_duty(input logic [PowerW-1:0] p);
        logic [16:0] prod;
        prod = 17'({10'd0, p} * 17'd1065);
        return INHALE_BASE + DutyW'(prod[16:10]);
    endfunction

endpackage

[design/rfdc_step.sv]
// One control tick: apply requests, advance direction and pause, form outputs
module rfdc_step (
    input  rfdc_pkg::t_state             i_state,
    input  rfdc_pkg::t_item              i_item,
    input  logic [rfdc_pkg::CfgW-1:0]    i_cycle_period_ms,
    input  logic [rfdc_pkg::CfgW-1:0]    i_reversal_pause_ms,
    output rfdc_pkg::t_state             o_state,
    output rfdc_pkg::t_result            o_result
);

    always_comb begin
        rfdc_pkg::t_state                s;
        logic                            req_chg;
        logic                            off;
        logic                            new_dir;
        logic [rfdc_pkg::TimeW-1:0]      limit;
        logic [rfdc_pkg::TimeW-1:0]      elapsed;
        logic signed [7:0]               pwr;

        s = i_state;

        // Take the requests
        req_chg = (i_item.power_request != {1'b0, i_state.stored_power}) ||
                  (i_item.mode_request != i_state.stored_mode);
        if (req_chg) begin
            if (i_state.stored_power == '0) begin
                s.direction_inward = (i_item.mode_request == rfdc_pkg::MODE_INHALE);
                s.last_change_ms   = i_item.now_ms;
            end
            s.stored_mode = i_item.mode_request;
            if (i_item.power_request != '0 && i_item.power_request <= rfdc_pkg::MAX_POWER)
                s.stored_power = i_item.power_request[rfdc_pkg::PowerW-1:0];
            else
                s.stored_power = '0;
        end

        // Drive the fan
        off     = (s.stored_power == '0) || i_item.stop_request;
        limit   = {1'b0, i_cycle_period_ms} + {1'b0, i_reversal_pause_ms};
        elapsed = i_item.now_ms - s.last_change_ms;
        new_dir = s.direction_inward;
        o_result.fan_duty = rfdc_pkg::NEUTRAL_DUTY;
        o_result.relay_on = 1'b0;
        if (off) begin
            s.in_pause = 1'b0;
        end else begin
            o_result.relay_on = 1'b1;
            if (elapsed > limit) begin
                case (s.stored_mode)
                    rfdc_pkg::MODE_EXHALE:  new_dir = 1'b0;
                    rfdc_pkg::MODE_INHALE:  new_dir = 1'b1;
                    rfdc_pkg::MODE_RECYCLE: new_dir = ~s.direction_inward;
                    default:                new_dir = s.direction_inward;
                endcase
                if (new_dir != s.direction_inward) begin
                    s.last_change_ms = i_item.now_ms;
                    elapsed          = '0;
                end
                s.direction_inward = new_dir;
            end
            s.in_pause = (elapsed < {1'b0, i_reversal_pause_ms});
            if (!s.in_pause) begin
                if (s.direction_inward)
                    o_result.fan_duty = rfdc_pkg::inhale_duty(s.stored_power);
                else
                    o_result.fan_duty = rfdc_pkg::EXHALE_BASE - {1'b0, s.stored_power};
            end
        end

        // Report signed power
        pwr = $signed({1'b0, s.stored_power});
        if (i_item.stop_request)
            o_result.set_power = '0;
        else if (s.direction_inward)
            o_result.set_power = pwr;
        else
            o_result.set_power = -pwr;
        o_result.actual_power = s.in_pause ? 8'sd0 : o_result.set_power;
        o_result.reversing    = s.in_pause;

        o_state = s;
    end

endmodule

[design/reversing_fan_direction_controller_core.sv]
// Reversing fan direction controller. Each input item is one control tick
// (timestamp, power and mode request, stop flag) and yields exactly one result
// item with the fan duty, relay enable, signed set and actual power, and the
// reversal-pause flag. Items pass through an input register and a result
// register with all tick logic in between, so one item is taken per clock
// unless the result stream stalls; a result is offered once its item has
// moved into the result register. Controller state carries over from tick
// to tick in place, so back-to-back items see each other's updates. The user
// writes cycle_period_ms at byte address 0 and reversal_pause_ms at 4
// through the APB port only while idle; the block does not enforce this.
module reversing_fan_direction_controller_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // now_ms[31:0], power_request[39:32], mode_request[41:40], stop_request[42]
    input  logic [rfdc_pkg::InDataW-1:0]   s_axis_tdata,
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // fan_duty[7:0], relay_on[8], set_power[16:9], actual_power[24:17],
    // reversing[25]
    output logic [rfdc_pkg::OutDataW-1:0]  m_axis_tdata
);

    logic [rfdc_pkg::CfgW-1:0] r_cycle_period_ms;
    logic [rfdc_pkg::CfgW-1:0] r_reversal_pause_ms;
    rfdc_pkg::t_state          r_state;
    rfdc_pkg::t_state          n_state;
    rfdc_pkg::t_item           r_item;
    logic                      r_in_valid;
    logic                      r_out_valid;
    rfdc_pkg::t_result         r_result;
    rfdc_pkg::t_result         n_result;
    logic                      out_free;
    logic                      advance;

    // Configuration writes and reads
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_period_ms   <= '0;
            r_reversal_pause_ms <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                rfdc_pkg::REG_CYCLE_PERIOD:   r_cycle_period_ms   <= pwdata[rfdc_pkg::CfgW-1:0];
                rfdc_pkg::REG_REVERSAL_PAUSE: r_reversal_pause_ms <= pwdata[rfdc_pkg::CfgW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            rfdc_pkg::REG_CYCLE_PERIOD:   prdata = {1'b0, r_cycle_period_ms};
            rfdc_pkg::REG_REVERSAL_PAUSE: prdata = {1'b0, r_reversal_pause_ms};
            default:                      prdata = '0;
        endcase
    end

    // Handshake: move an item on when the result register is free
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Unpack the item fields from the lowest bit up
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.now_ms        <= s_axis_tdata[31:0];
            r_item.power_request <= s_axis_tdata[39:32];
            r_item.mode_request  <= s_axis_tdata[41:40];
            r_item.stop_request  <= s_axis_tdata[42];
        end
    end

    rfdc_step u_step (
        .i_state             (r_state),
        .i_item              (r_item),
        .i_cycle_period_ms   (r_cycle_period_ms),
        .i_reversal_pause_ms (r_reversal_pause_ms),
        .o_state             (n_state),
        .o_result            (n_result)
    );

    // Controller state advances with each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_result.reversing, r_result.actual_power,
                            r_result.set_power, r_result.relay_on, r_result.fan_duty};

endmodule

[design/rfdc_checker.sv]
// Port-level checks on result items
module rfdc_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [rfdc_pkg::OutDataW-1:0]  m_axis_tdata
);

    logic [7:0] duty;
    logic       relay;
    logic [7:0] setp;
    logic [7:0] actp;
    logic       rev;

    assign duty  = m_axis_tdata[7:0];
    assign relay = m_axis_tdata[8];
    assign setp  = m_axis_tdata[16:9];
    assign actp  = m_axis_tdata[24:17];
    assign rev   = m_axis_tdata[25];

    // Relay off means neutral duty and no power
    a_off_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !relay) |->
            (duty == rfdc_pkg::NEUTRAL_DUTY && setp == 8'd0 && actp == 8'd0 && !rev))
        else $error("relay off with non-neutral output");

    // Pause holds neutral duty and zero actual power
    a_pause_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && rev) |-> (duty == rfdc_pkg::NEUTRAL_DUTY && actp == 8'd0))
        else $error("reversal pause with drive");

    // Running fan never sits at neutral duty and reports actual equal to set
    a_run_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && relay && !rev) |->
            (duty != rfdc_pkg::NEUTRAL_DUTY && actp == setp))
        else $error("running fan with neutral duty");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule

bind reversing_fan_direction_controller_core rfdc_checker u_rfdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/tb_reversing_fan_direction_controller_core.sv]
`timescale 1ns / 1ps

module tb_reversing_fan_direction_controller_core;

    localparam int unsigned IDLE_LIMIT = 2000;
    localparam logic [rfdc_pkg::CfgW-1:0] CFG_MAX = 31'h7FFF_FFFF;

    // Tracks controller state per accepted tick and holds the outputs it predicts
    class fan_tick_board;
        logic [rfdc_pkg::CfgW-1:0]   period_ms;
        logic [rfdc_pkg::CfgW-1:0]   pause_ms;
        logic [rfdc_pkg::PowerW-1:0] level;
        logic [rfdc_pkg::ModeW-1:0]  mode;
        logic                        inward;
        logic [rfdc_pkg::TimeW-1:0]  last_turn_ms;
        logic                        paused;
        rfdc_pkg::t_result           pending_fan_outputs[$];
        int                          errors;

        function new();
            period_ms = '0;
            pause_ms = '0;
            level = '0;
            mode = rfdc_pkg::MODE_RECYCLE;
            inward = 1'b0;
            last_turn_ms = '0;
            paused = 1'b0;
            errors = 0;
        endfunction

        function void set_timing(logic idx, logic [rfdc_pkg::CfgW-1:0] val);
            if (idx == rfdc_pkg::REG_CYCLE_PERIOD) begin
                period_ms = val;
            end else begin
                pause_ms = val;
            end
        endfunction

        // Run one control tick and queue the output it yields
        function void take_tick(rfdc_pkg::t_item it);
            logic [rfdc_pkg::TimeW-1:0] elapsed;
            logic [rfdc_pkg::TimeW:0]   span;
            logic                       prev;
            logic signed [7:0]          mag;
            int                         lift;
            rfdc_pkg::t_result          r;
            // Apply new requests; an idle fan seeds direction and turn time
            if (it.power_request != {1'b0, level} || it.mode_request != mode) begin
                if (level == 0) begin
                    inward = (it.mode_request == rfdc_pkg::MODE_INHALE);
                    last_turn_ms = it.now_ms;
                end
                mode = it.mode_request;
                level = (it.power_request >= 1 && it.power_request <= rfdc_pkg::MAX_POWER) ?
                        it.power_request[rfdc_pkg::PowerW-1:0] : '0;
            end
            r.relay_on = 1'b0;
            r.fan_duty = rfdc_pkg::NEUTRAL_DUTY;
            if (level == 0 || it.stop_request) begin
                paused = 1'b0;
            end else begin
                r.relay_on = 1'b1;
                span = {2'b00, period_ms} + {2'b00, pause_ms};
                elapsed = it.now_ms - last_turn_ms;
                // Turn once the period plus the pause has run out
                if ({1'b0, elapsed} > span) begin
                    prev = inward;
                    case (mode)
                        rfdc_pkg::MODE_EXHALE:  inward = 1'b0;
                        rfdc_pkg::MODE_INHALE:  inward = 1'b1;
                        rfdc_pkg::MODE_RECYCLE: inward = !inward;
                        default: ;
                    endcase
                    if (prev != inward) last_turn_ms = it.now_ms;
                end
                elapsed = it.now_ms - last_turn_ms;
                paused = (elapsed < {1'b0, pause_ms});
                if (!paused) begin
                    if (inward) begin
                        lift = (int'(level) * 104) / 100;
                        r.fan_duty = rfdc_pkg::INHALE_BASE + lift[rfdc_pkg::DutyW-1:0];
                    end else begin
                        r.fan_duty = rfdc_pkg::EXHALE_BASE - {1'b0, level};
                    end
                end
            end
            mag = {1'b0, level};
            r.set_power = it.stop_request ? 8'sd0 : (inward ? mag : -mag);
            r.actual_power = paused ? 8'sd0 : r.set_power;
            r.reversing = paused;
            pending_fan_outputs.push_back(r);
        endfunction

        function void compare_field(string name, int expv, int act);
            if (expv != act) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, act);
            end
        endfunction

        // Compare one result item against the oldest prediction
        function void match_output(logic [rfdc_pkg::OutDataW-1:0] data);
            rfdc_pkg::t_result e;
            if (pending_fan_outputs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                return;
            end
            e = pending_fan_outputs.pop_front();
            compare_field("fan_duty", int'(e.fan_duty), int'(data[7:0]));
            compare_field("relay_on", int'(e.relay_on), int'(data[8]));
            compare_field("set_power", int'(e.set_power), int'($signed(data[16:9])));
            compare_field("actual_power", int'(e.actual_power), int'($signed(data[24:17])));
            compare_field("reversing", int'(e.reversing), int'(data[25]));
        endfunction

        function int outstanding();
            return pending_fan_outputs.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [2:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    // now_ms, power_request, mode_request, stop_request from bit 0 up
    logic [rfdc_pkg::InDataW-1:0]  s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // fan_duty, relay_on, set_power, actual_power, reversing from bit 0 up
    logic [rfdc_pkg::OutDataW-1:0] m_axis_tdata;

    fan_tick_board board;
    int                  burst_left;
    bit                  gapless;
    int unsigned         idle_cycles;
    int unsigned         rx_cycle;
    int unsigned         rx_style;

    reversing_fan_direction_controller_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Drive the result-side ready from one of four randomly chosen patterns
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 128 == 0) rx_style <= $urandom_range(0, 3);
        case (rx_style)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom % 4 != 0);
            2: m_axis_tready <= ($urandom % 2 == 0);
            default: m_axis_tready <= (rx_cycle % 8 < 5);
        endcase
    end

    // Check every accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.match_output(m_axis_tdata);
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one tick item, opening a random gap when a burst runs out
    task automatic push_tick(input rfdc_pkg::t_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = (gapless || $urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, it.stop_request, it.mode_request, it.power_request, it.now_ms};
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_tick(it);
        burst_left--;
    endtask

    task automatic tick(input logic [rfdc_pkg::TimeW-1:0] now,
                        input logic [rfdc_pkg::ReqW-1:0] pw,
                        input logic [rfdc_pkg::ModeW-1:0] md, input logic stop);
        rfdc_pkg::t_item it;
        it.now_ms = now;
        it.power_request = pw;
        it.mode_request = md;
        it.stop_request = stop;
        push_tick(it);
    endtask

    // Drop valid and wait for every predicted result to arrive
    task automatic drain;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.outstanding() > 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic reg_write(input logic idx, input logic [rfdc_pkg::CfgW-1:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {1'b0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_timing(idx, val);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        logic [rfdc_pkg::CfgW-1:0]  period;
        logic [rfdc_pkg::CfgW-1:0]  hold;
        logic [rfdc_pkg::TimeW-1:0] now;
        logic [rfdc_pkg::TimeW-1:0] span;
        logic [rfdc_pkg::ReqW-1:0]  pw;
        logic [rfdc_pkg::ModeW-1:0] md;
        int unsigned                rnd;
        int                         sel;
        int                         run;
        int                         done;

        board = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        burst_left = 0;
        gapless = 1'b0;
        idle_cycles = 0;
        rx_cycle = 0;
        rx_style = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks at reset timing: off, seeding, every mode, bad powers
        tick(32'd0, 8'd0, rfdc_pkg::MODE_RECYCLE, 1'b0);
        tick(32'd1, 8'd1, rfdc_pkg::MODE_INHALE, 1'b0);
        tick(32'd2, 8'd100, rfdc_pkg::MODE_INHALE, 1'b0);
        tick(32'd3, 8'd100, rfdc_pkg::MODE_EXHALE, 1'b0);
        tick(32'd4, 8'd101, rfdc_pkg::MODE_EXHALE, 1'b0);
        tick(32'd5, 8'd255, 2'd3, 1'b0);
        tick(32'd6, 8'd50, 2'd3, 1'b0);
        tick(32'd7, 8'd50, 2'd3, 1'b1);
        tick(32'd8, 8'd50, rfdc_pkg::MODE_RECYCLE, 1'b0);
        tick(32'd9, 8'd50, rfdc_pkg::MODE_RECYCLE, 1'b0);
        tick(32'd9, 8'd50, rfdc_pkg::MODE_RECYCLE, 1'b0);
        tick(32'd10, 8'd50, rfdc_pkg::MODE_RECYCLE, 1'b1);
        tick(32'hFFFF_FFFF, 8'd128, rfdc_pkg::MODE_INHALE, 1'b0);
        drain();

        // Directed ticks with a short period and pause, across the time wrap
        reg_write(rfdc_pkg::REG_CYCLE_PERIOD, 31'd4);
        reg_write(rfdc_pkg::REG_REVERSAL_PAUSE, 31'd2);
        tick(32'hFFFF_FFFC, 8'd70, rfdc_pkg::MODE_RECYCLE, 1'b0);
        tick(32'hFFFF_FFFE, 8'd70, rfdc_pkg::MODE_RECYCLE, 1'b0);
        tick(32'h0000_0002, 8'd70, rfdc_pkg::MODE_RECYCLE, 1'b0);
        tick(32'h0000_0003, 8'd70, rfdc_pkg::MODE_RECYCLE, 1'b0);
        tick(32'h0000_0004, 8'd70, rfdc_pkg::MODE_RECYCLE, 1'b0);
        tick(32'h0000_0005, 8'd70, rfdc_pkg::MODE_EXHALE, 1'b0);
        tick(32'h0000_000C, 8'd70, rfdc_pkg::MODE_INHALE, 1'b0);
        tick(32'h0000_0013, 8'd70, rfdc_pkg::MODE_INHALE, 1'b0);
        tick(32'h0000_0014, 8'd0, rfdc_pkg::MODE_INHALE, 1'b0);
        tick(32'h7FFF_FFFF, 8'd127, rfdc_pkg::MODE_RECYCLE, 1'b1);
        drain();

        // Random phases, extremes of the timing registers first
        for (int ph = 0; ph < 16; ph++) begin
            sel = (ph < 4) ? ph : $urandom_range(3, 9);
            case (sel)
                0: begin period = CFG_MAX; hold = CFG_MAX; end
                1: begin period = CFG_MAX; hold = '0; end
                2: begin period = '0; hold = CFG_MAX; end
                3: begin period = '0; hold = '0; end
                default: begin
                    rnd = $urandom_range(0, 40);
                    period = rnd[rfdc_pkg::CfgW-1:0];
                    rnd = $urandom_range(0, 12);
                    hold = rnd[rfdc_pkg::CfgW-1:0];
                end
            endcase
            reg_write(rfdc_pkg::REG_CYCLE_PERIOD, period);
            reg_write(rfdc_pkg::REG_REVERSAL_PAUSE, hold);
            span = {1'b0, period} + {1'b0, hold};
            now = ($urandom % 3 == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200) : $urandom;
            gapless = ($urandom % 4 == 0);
            done = 0;
            while (done < 50) begin
                if ($urandom % 6 == 0) begin
                    // Noise: any power, any mode, any stop
                    now = now + $urandom_range(0, 20);
                    rnd = $urandom_range(0, 255);
                    pw = rnd[rfdc_pkg::ReqW-1:0];
                    rnd = $urandom_range(0, 3);
                    md = rnd[rfdc_pkg::ModeW-1:0];
                    rnd = $urandom;
                    tick(now, pw, md, rnd[0]);
                    done++;
                end else begin
                    // A session: steady requests with the clock moving on
                    rnd = $urandom_range(1, 100);
                    pw = ($urandom % 8 == 0) ? 8'd0 : rnd[rfdc_pkg::ReqW-1:0];
                    rnd = $urandom_range(0, 2);
                    md = ($urandom % 20 == 0) ? 2'd3 : rnd[rfdc_pkg::ModeW-1:0];
                    run = $urandom_range(3, 25);
                    for (int k = 0; k < run && done < 50; k++) begin
                        sel = $urandom % 100;
                        if (sel < 4) now = now + $urandom;
                        else if (sel < 6) now = now + 32'hFFFF_FFFF;
                        else if (sel < 10) now = now + span + $urandom_range(0, 2);
                        else if (sel < 14) now = now + hold - 1 + $urandom_range(0, 2);
                        else now = now + $urandom_range(0, (span < 40) ? span + 4 : 12);
                        tick(now, pw, md, ($urandom % 12 == 0));
                        done++;
                    end
                end
            end
            drain();
        end

        gapless = 1'b0;
        repeat (8) @(posedge i_clk);
        board.errors += board.outstanding();
        if (board.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
